// File: rtl/sldca_pkg.sv
// sldca_pkg: widths, coefficients, register indexes and microcode types for the
// stereo lo-fi core; helper functions for rounding, hold limit and crush level.
// no dependencies; compiled first.
package sldca_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int HOLD_W     = 7;
	localparam int INTEN_W    = 17;
	localparam int SMOOTH_W   = 28;
	localparam int ALIAS_W    = 26;
	localparam int M_W        = 15;
	localparam int DIV_W      = 16;
	localparam int MULA_W     = 28;
	localparam int MULB_W     = 24;
	localparam int PROD_W     = 49;
	localparam int ACC_W      = 45;
	localparam int CNT_W      = 5;
	localparam int DIV_STEPS  = 24;
	localparam int RND_SH_HI  = 23;
	localparam int RND_SH_LO  = 16;
	localparam int CRUSH_TOP  = 15;

	localparam logic [HOLD_W-1:0]  HOLD_MAX   = 7'd64;
	localparam logic [HOLD_W-1:0]  HOLD_MIN   = 7'd1;
	localparam logic [INTEN_W-1:0] INTEN_ONE  = 17'h10000;
	localparam logic [CNT_W-1:0]   DIV_LAST   = CNT_W'(DIV_STEPS - 1);

	// Q0.16 coefficients
	localparam logic [15:0] C_POLE = 16'd52429;
	localparam logic [15:0] C_FEED = 16'd13107;
	localparam logic [15:0] C_MIX  = 16'd3277;

	localparam logic [PROD_W-1:0] RND_HALF_HI = PROD_W'(1) << (RND_SH_HI - 1);
	localparam logic [PROD_W-1:0] RND_HALF_LO = PROD_W'(1) << (RND_SH_LO - 1);
	localparam logic [PROD_W-1:0] SMOOTH_POS_LIM = (PROD_W'(1) << (SMOOTH_W - 1)) - PROD_W'(1);
	localparam logic [PROD_W-1:0] SMOOTH_NEG_LIM = PROD_W'(1) << (SMOOTH_W - 1);

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_INTENSITY = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [3:0] pc_t;

	// microcode program addresses
	localparam pc_t PC_IDLE   = 4'd0;
	localparam pc_t PC_HOLD   = 4'd1;
	localparam pc_t PC_MULQ   = 4'd2;
	localparam pc_t PC_DIVLD  = 4'd3;
	localparam pc_t PC_DIV    = 4'd4;
	localparam pc_t PC_CRUSH  = 4'd5;
	localparam pc_t PC_SQ     = 4'd6;
	localparam pc_t PC_POLE   = 4'd7;
	localparam pc_t PC_FEED   = 4'd8;
	localparam pc_t PC_ACCADD = 4'd9;
	localparam pc_t PC_SMOOTH = 4'd10;
	localparam pc_t PC_MIX    = 4'd11;
	localparam pc_t PC_RESULT = 4'd12;
	localparam pc_t PC_EMIT   = 4'd13;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_HOLD,
		OP_DIVLOAD,
		OP_DIVSTEP,
		OP_CRUSH,
		OP_ALIAS,
		OP_ACCLOAD,
		OP_ACCADD,
		OP_SMOOTH,
		OP_RESULT,
		OP_EMIT
	} op_e;

	typedef enum logic [1:0] {
		MA_HELD,
		MA_DMAG,
		MA_SMOOTH,
		MA_ALIAS
	} mula_e;

	typedef enum logic [2:0] {
		MB_M,
		MB_DMAG,
		MB_POLE,
		MB_FEED,
		MB_MIX
	} mulb_e;

	typedef enum logic [1:0] {
		W_NONE,
		W_IN,
		W_OUT
	} wait_e;

	typedef enum logic [1:0] {
		BR_NONE,
		BR_DIV,
		BR_CHAN,
		BR_ALWAYS
	} branch_e;

	typedef struct packed {
		op_e     op;
		logic    mul_en;
		mula_e   mula;
		mulb_e   mulb;
		wait_e   wt;
		branch_e br;
		pc_t     target;
	} ucode_t;

	function automatic ucode_t uw(input op_e op, input logic mul_en, input mula_e a,
			input mulb_e b, input wait_e wt, input branch_e br, input pc_t target);
		ucode_t w;
		w.op     = op;
		w.mul_en = mul_en;
		w.mula   = a;
		w.mulb   = b;
		w.wt     = wt;
		w.br     = br;
		w.target = target;
		return w;
	endfunction

	// control store: one word per step, same program for both channels
	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		unique case (pc)
			PC_IDLE:   w = uw(OP_ACCEPT,  1'b0, MA_HELD,   MB_M,    W_IN,   BR_NONE,   PC_IDLE);
			PC_HOLD:   w = uw(OP_HOLD,    1'b0, MA_HELD,   MB_M,    W_NONE, BR_NONE,   PC_IDLE);
			PC_MULQ:   w = uw(OP_NONE,    1'b1, MA_HELD,   MB_M,    W_NONE, BR_NONE,   PC_IDLE);
			PC_DIVLD:  w = uw(OP_DIVLOAD, 1'b0, MA_HELD,   MB_M,    W_NONE, BR_NONE,   PC_IDLE);
			PC_DIV:    w = uw(OP_DIVSTEP, 1'b0, MA_HELD,   MB_M,    W_NONE, BR_DIV,    PC_DIV);
			PC_CRUSH:  w = uw(OP_CRUSH,   1'b0, MA_HELD,   MB_M,    W_NONE, BR_NONE,   PC_IDLE);
			PC_SQ:     w = uw(OP_NONE,    1'b1, MA_DMAG,   MB_DMAG, W_NONE, BR_NONE,   PC_IDLE);
			PC_POLE:   w = uw(OP_ALIAS,   1'b1, MA_SMOOTH, MB_POLE, W_NONE, BR_NONE,   PC_IDLE);
			PC_FEED:   w = uw(OP_ACCLOAD, 1'b1, MA_ALIAS,  MB_FEED, W_NONE, BR_NONE,   PC_IDLE);
			PC_ACCADD: w = uw(OP_ACCADD,  1'b0, MA_HELD,   MB_M,    W_NONE, BR_NONE,   PC_IDLE);
			PC_SMOOTH: w = uw(OP_SMOOTH,  1'b0, MA_HELD,   MB_M,    W_NONE, BR_NONE,   PC_IDLE);
			PC_MIX:    w = uw(OP_NONE,    1'b1, MA_SMOOTH, MB_MIX,  W_NONE, BR_NONE,   PC_IDLE);
			PC_RESULT: w = uw(OP_RESULT,  1'b0, MA_HELD,   MB_M,    W_NONE, BR_CHAN,   PC_HOLD);
			PC_EMIT:   w = uw(OP_EMIT,    1'b0, MA_HELD,   MB_M,    W_OUT,  BR_ALWAYS, PC_IDLE);
			default:   w = uw(OP_NONE,    1'b0, MA_HELD,   MB_M,    W_NONE, BR_ALWAYS, PC_IDLE);
		endcase
		return w;
	endfunction

	// magnitude of round(v / 2^sh), half away from zero
	function automatic logic [PROD_W-1:0] rnd_mag(input logic signed [PROD_W-1:0] v,
			input logic sh_hi);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] sum;
		mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		if (sh_hi) begin
			sum = mag + RND_HALF_HI;
			return sum >> RND_SH_HI;
		end else begin
			sum = mag + RND_HALF_LO;
			return sum >> RND_SH_LO;
		end
	endfunction

	// hold time limited to 1..HOLD_MAX
	function automatic logic [HOLD_W-1:0] hold_limit(input logic [HOLD_W-1:0] h);
		if (h < HOLD_MIN)
			return HOLD_MIN;
		else if (h > HOLD_MAX)
			return HOLD_MAX;
		else
			return h;
	endfunction

	// quantizer scale 2^(bits-1)-1, bits = 16 - ceil(4*intensity)
	function automatic logic [M_W-1:0] crush_level(input logic [INTEN_W-1:0] inten_in);
		logic [INTEN_W-1:0] inten;
		logic [2:0]         steps;
		logic [3:0]         sh;
		inten = (inten_in > INTEN_ONE) ? INTEN_ONE : inten_in;
		steps = inten[16:14] + 3'(|inten[13:0]);
		sh    = 4'(CRUSH_TOP) - 4'(steps);
		return M_W'((16'd1 << sh) - 16'd1);
	endfunction

endpackage

// File: rtl/sldca_if.sv
// sldca_in_if / sldca_out_if: valid-ready channels for sample pairs and results
// depends on sldca_pkg for the sample type
interface sldca_in_if;
	import sldca_pkg::*;

	logic    valid;
	logic    ready;
	sample_t left_sample;
	sample_t right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface sldca_out_if;
	import sldca_pkg::*;

	logic    valid;
	logic    ready;
	sample_t left_out;
	sample_t right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// File: rtl/stereo_lofi_decimate_crush_alias_core.sv
// stereo_lofi_decimate_crush_alias_core: microcoded stereo decimator, bit crusher
// and aliasing term; depends on sldca_pkg and the channels in sldca_if.sv
//
//   port      dir   handshake      word contents
//   samples   sink  valid/ready    left_sample, right_sample (signed 24)
//   results   src   valid/ready    left_out, right_out (signed 24, saturated)
//   cfg_*     in    cfg_we only    cfg_index 0 hold_time, 1 intensity
//
// one word runs through accept, 35 steps per channel and one emit step
// most of those steps are the restoring divider: 24 steps, one quotient bit a cycle, run twice
// one shared 28x25 multiplier, product registered before every use
// a finished word waits in the output register; the next word is taken meanwhile
// the emit step stalls only while the output register is full and not taken
// reset clears config to hold_time 1, intensity 0 and hold counts, held, previous and smoothed values to zero
module stereo_lofi_decimate_crush_alias_core (
	input  logic                              clk,
	input  logic                              arst_n,
	sldca_in_if.sink                          samples,
	sldca_out_if.source                       results,
	input  logic                              cfg_we,
	input  logic [sldca_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sldca_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sldca_pkg::*;

	// config registers
	logic [HOLD_W-1:0]  hold_time_q;
	logic [INTEN_W-1:0] intensity_q;

	// sequencer
	pc_t        pc_q;
	pc_t        pc_next;
	ucode_t     uc;
	logic       stall;
	logic       step;
	logic       br_taken;
	logic       ch_q;
	logic [CNT_W-1:0] cnt_q;

	// per-channel state, indexed by the channel being worked on
	sample_t                    in_q     [2];
	logic [HOLD_W-1:0]          hold_cnt_q [2];
	sample_t                    held_q   [2];
	sample_t                    prev_q   [2];
	logic signed [SMOOTH_W-1:0] smooth_q [2];
	sample_t                    res_q    [2];

	// datapath registers
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic [DIV_W-1:0]           rem_q;
	logic [SAMPLE_W-1:0]        num_q;
	logic                       qneg_q;
	sample_t                    crushed_q;
	logic [SAMPLE_W-1:0]        dmag_q;
	logic                       dneg_q;
	logic signed [ALIAS_W-1:0]  alias_q;

	// output register
	logic    out_valid_q;
	sample_t out_left_q;
	sample_t out_right_q;

	// derived config
	logic [M_W-1:0]    m;
	logic [DIV_W-1:0]  div_d;
	logic [HOLD_W-1:0] hold_eff;

	logic out_fire;
	logic out_busy;

	// multiplier
	logic signed [MULA_W-1:0]        mul_a;
	logic [MULB_W-1:0]               mul_b;
	logic signed [MULA_W+MULB_W:0]   mul_p;

	// shared rounding unit
	logic signed [PROD_W-1:0] rnd_in;
	logic                     rnd_hi;
	logic [PROD_W-1:0]        rnd_v;
	logic                     rnd_neg;

	// step results
	logic [HOLD_W-1:0]          cnt_inc;
	logic                       capture;
	logic [DIV_W:0]             div_t;
	logic                       div_ge;
	logic signed [SAMPLE_W:0]   neg_mag;
	sample_t                    crushed_c;
	logic signed [SAMPLE_W:0]   d_c;
	logic signed [SAMPLE_W:0]   d_abs;
	logic signed [ALIAS_W-1:0]  alias_c;
	logic signed [SMOOTH_W:0]   smooth_neg;
	logic signed [SMOOTH_W-1:0] smooth_c;
	logic signed [SAMPLE_W+1:0] mix_c;
	logic signed [SAMPLE_W+1:0] sum_c;
	sample_t                    out_c;

	assign m        = crush_level(intensity_q);
	assign div_d    = {m, 1'b0};
	assign hold_eff = hold_limit(hold_time_q);

	assign uc = ucode_rom(pc_q);

	// handshakes
	assign samples.ready = (uc.wt == W_IN);
	assign out_fire      = results.valid && results.ready;
	assign out_busy      = out_valid_q && !results.ready;

	assign results.valid     = out_valid_q;
	assign results.left_out  = out_left_q;
	assign results.right_out = out_right_q;

	// wait conditions hold the step counter and block the step's side effects
	always_comb begin
		case (uc.wt)
			W_IN:    stall = !samples.valid;
			W_OUT:   stall = out_busy;
			default: stall = 1'b0;
		endcase
	end
	assign step = !stall;

	always_comb begin
		case (uc.br)
			BR_DIV:    br_taken = (cnt_q != DIV_LAST);
			BR_CHAN:   br_taken = !ch_q;
			BR_ALWAYS: br_taken = 1'b1;
			default:   br_taken = 1'b0;
		endcase
	end

	always_comb begin
		if (stall)
			pc_next = pc_q;
		else if (br_taken)
			pc_next = uc.target;
		else
			pc_next = pc_q + pc_t'(1);
	end

	// operand select for the shared multiplier
	always_comb begin
		case (uc.mula)
			MA_DMAG:   mul_a = MULA_W'($signed({1'b0, dmag_q}));
			MA_SMOOTH: mul_a = smooth_q[ch_q];
			MA_ALIAS:  mul_a = MULA_W'(alias_q);
			default:   mul_a = MULA_W'(held_q[ch_q]);
		endcase
	end

	always_comb begin
		case (uc.mulb)
			MB_DMAG: mul_b = dmag_q;
			MB_POLE: mul_b = MULB_W'(C_POLE);
			MB_FEED: mul_b = MULB_W'(C_FEED);
			MB_MIX:  mul_b = MULB_W'(C_MIX);
			default: mul_b = MULB_W'(m);
		endcase
	end

	assign mul_p = mul_a * $signed({1'b0, mul_b});

	// rounding: by 2^23 for the quantizer and the alias square, by 2^16 otherwise
	assign rnd_in  = (uc.op == OP_SMOOTH) ? PROD_W'(acc_q) : prod_q;
	assign rnd_hi  = (uc.op == OP_DIVLOAD) || (uc.op == OP_ALIAS);
	assign rnd_v   = rnd_mag(rnd_in, rnd_hi);
	assign rnd_neg = rnd_in[PROD_W-1];

	// sample-and-hold: count up, capture when the count reaches the hold time
	assign cnt_inc = hold_cnt_q[ch_q] + HOLD_W'(1);
	assign capture = (cnt_inc >= hold_eff);

	// restoring divider, numerator 2|q|*2^23 + m over 2m, quotient shifts into num_q
	assign div_t  = {rem_q, num_q[SAMPLE_W-1]};
	assign div_ge = (div_t >= {1'b0, div_d});

	// requantized value; only +1.0 can exceed the sample range
	always_comb begin
		neg_mag = -$signed({1'b0, num_q});
		if (qneg_q)
			crushed_c = neg_mag[SAMPLE_W-1:0];
		else if (num_q[SAMPLE_W-1])
			crushed_c = {1'b0, {(SAMPLE_W-1){1'b1}}};
		else
			crushed_c = $signed(num_q);
	end

	assign d_c   = $signed({crushed_c[SAMPLE_W-1], crushed_c})
	             - $signed({prev_q[ch_q][SAMPLE_W-1], prev_q[ch_q]});
	assign d_abs = d_c[SAMPLE_W] ? -d_c : d_c;

	// signed square of the change, back to Q1.23 scale
	assign alias_c = dneg_q ? -$signed({1'b0, rnd_v[ALIAS_W-2:0]})
	                        : $signed({1'b0, rnd_v[ALIAS_W-2:0]});

	// one-pole state, saturated to its 28-bit range
	always_comb begin
		smooth_neg = -$signed({1'b0, rnd_v[SMOOTH_W-1:0]});
		if (!rnd_neg && (rnd_v > SMOOTH_POS_LIM))
			smooth_c = {1'b0, {(SMOOTH_W-1){1'b1}}};
		else if (rnd_neg && (rnd_v > SMOOTH_NEG_LIM))
			smooth_c = {1'b1, {(SMOOTH_W-1){1'b0}}};
		else if (rnd_neg)
			smooth_c = smooth_neg[SMOOTH_W-1:0];
		else
			smooth_c = $signed(rnd_v[SMOOTH_W-1:0]);
	end

	// mix 0.05 of the state into the crushed sample, saturate to 24 bits
	always_comb begin
		mix_c = rnd_neg ? -$signed({2'b00, rnd_v[SAMPLE_W-1:0]})
		                : $signed({2'b00, rnd_v[SAMPLE_W-1:0]});
		sum_c = $signed({{2{crushed_q[SAMPLE_W-1]}}, crushed_q}) + mix_c;
		if (sum_c > $signed((SAMPLE_W+2)'((1 << (SAMPLE_W-1)) - 1)))
			out_c = {1'b0, {(SAMPLE_W-1){1'b1}}};
		else if (sum_c < -$signed((SAMPLE_W+2)'(1 << (SAMPLE_W-1))))
			out_c = {1'b1, {(SAMPLE_W-1){1'b0}}};
		else
			out_c = sum_c[SAMPLE_W-1:0];
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_time_q <= HOLD_MIN;
			intensity_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HOLD_TIME: hold_time_q <= cfg_data[HOLD_W-1:0];
				REG_INTENSITY: intensity_q <= cfg_data[INTEN_W-1:0];
			endcase
		end
	end

	// sequencer, channel state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_IDLE;
			ch_q        <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				hold_cnt_q[i] <= '0;
				held_q[i]     <= '0;
				prev_q[i]     <= '0;
				smooth_q[i]   <= '0;
			end
		end else begin
			pc_q <= pc_next;
			// a new word may load in the same cycle the old one is taken
			if (step && (uc.op == OP_EMIT))
				out_valid_q <= 1'b1;
			else if (out_fire)
				out_valid_q <= 1'b0;
			if (step) begin
				case (uc.op)
					OP_ACCEPT: ch_q <= 1'b0;
					OP_HOLD: begin
						hold_cnt_q[ch_q] <= capture ? '0 : cnt_inc;
						if (capture)
							held_q[ch_q] <= in_q[ch_q];
					end
					OP_DIVLOAD: cnt_q <= '0;
					OP_DIVSTEP: cnt_q <= cnt_q + CNT_W'(1);
					OP_CRUSH:   prev_q[ch_q] <= crushed_c;
					OP_SMOOTH:  smooth_q[ch_q] <= smooth_c;
					OP_RESULT:  ch_q <= 1'b1;
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (step && uc.mul_en)
			prod_q <= mul_p[PROD_W-1:0];
		if (step) begin
			case (uc.op)
				OP_ACCEPT: begin
					in_q[0] <= samples.left_sample;
					in_q[1] <= samples.right_sample;
				end
				OP_DIVLOAD: begin
					rem_q  <= rnd_v[DIV_W-1:0];
					qneg_q <= rnd_neg;
					num_q  <= SAMPLE_W'(m);
				end
				OP_DIVSTEP: begin
					rem_q <= div_ge ? DIV_W'(div_t - {1'b0, div_d}) : div_t[DIV_W-1:0];
					num_q <= {num_q[SAMPLE_W-2:0], div_ge};
				end
				OP_CRUSH: begin
					crushed_q <= crushed_c;
					dmag_q    <= d_abs[SAMPLE_W-1:0];
					dneg_q    <= d_c[SAMPLE_W];
				end
				OP_ALIAS:   alias_q <= alias_c;
				OP_ACCLOAD: acc_q   <= prod_q[ACC_W-1:0];
				OP_ACCADD:  acc_q   <= acc_q + prod_q[ACC_W-1:0];
				OP_RESULT:  res_q[ch_q] <= out_c;
				OP_EMIT: begin
					out_left_q  <= res_q[0];
					out_right_q <= res_q[1];
				end
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/sldca_checker.sv
// sldca_checker: port-level checks on the stereo lo-fi core, bound to the top level
// depends on sldca_pkg and stereo_lofi_decimate_crush_alias_core
module sldca_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input sldca_pkg::sample_t left_out,
	input sldca_pkg::sample_t right_out
);
	import sldca_pkg::*;

	logic       in_fire;
	logic       out_fire;
	logic [1:0] pending_q;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else
			pending_q <= pending_q + 2'(in_fire) - 2'(out_fire);
	end

	// the core works on one word at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("ready stayed high after a word was taken");

	// no result without a word behind it
	a_result_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending_q != 2'd0))
		else $error("result shown with no word outstanding");

	// ready only while at most one finished word waits
	a_ready_with_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (pending_q <= 2'd1))
		else $error("ready with more than one word outstanding");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
		else $error("stalled result changed");

endmodule

bind stereo_lofi_decimate_crush_alias_core sldca_checker u_sldca_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.left_out  (results.left_out),
	.right_out (results.right_out)
);
